// File: rtl/smp_pkg.sv
// Shared types, constants and slot decode table for the stepper move planner.
package smp_pkg;

	// Sizes
	localparam int POSITION_BITS_DEF = 24;
	localparam int COUNT_W           = 18;
	localparam int SCALE_W           = 5;
	localparam int FRAC_BITS         = 7;
	localparam int MSP_W             = 9;
	localparam int SLOT_COUNT        = 22;
	localparam int SLOT_W            = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX    = 18'h3FFFF;
	localparam logic [SCALE_W-1:0] SCALE_RESET  = 5'd10;

	// Fixed slots of the command sequence
	localparam logic [SLOT_W-1:0] SLOT_FULL_MODE  = 5'd0;
	localparam logic [SLOT_W-1:0] SLOT_FULL_BURST = 5'd1;
	localparam logic [SLOT_W-1:0] SLOT_DONE       = 5'd21;

	// Driver step-mode codes written to CR3
	localparam logic [7:0] MODE_FULL = 8'd4;
	localparam logic [7:0] MODE_SUB  = 8'd7;
	localparam logic [7:0] MODE_64   = 8'd2;
	localparam logic [7:0] MODE_128  = 8'd1;

	// Sub-mode codes placed in CR0 bits 7:5 for 1/2 .. 1/32
	localparam logic [2:0] SUB_HALF = 3'd4;
	localparam logic [2:0] SUB_4    = 3'd3;
	localparam logic [2:0] SUB_8    = 3'd2;
	localparam logic [2:0] SUB_16   = 3'd1;
	localparam logic [2:0] SUB_32   = 3'd0;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_BURST = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_CR0 = 2'd0,
		REG_CR1 = 2'd1,
		REG_CR2 = 2'd2,
		REG_CR3 = 2'd3
	} reg_sel_t;

	typedef enum logic [1:0] {
		CNT_NONE = 2'd0,
		CNT_FULL = 2'd1,
		CNT_ONE  = 2'd2
	} count_src_t;

	typedef struct packed {
		kind_t      kind;
		reg_sel_t   sel;
		logic [7:0] value;
		count_src_t cnt;
	} slot_info_t;

	// What each slot of the sequence emits
	function automatic slot_info_t slot_info(input logic [SLOT_W-1:0] slot,
	                                         input logic [SCALE_W-1:0] scale);
		slot_info_t s;
		s.kind  = KIND_WRITE;
		s.sel   = REG_CR0;
		s.value = 8'd0;
		s.cnt   = CNT_NONE;
		unique case (slot) inside
			SLOT_FULL_MODE: begin
				s.sel   = REG_CR3;
				s.value = MODE_FULL;
			end
			SLOT_FULL_BURST: begin
				s.kind = KIND_BURST;
				s.cnt  = CNT_FULL;
			end
			5'd2, 5'd5, 5'd8, 5'd11, 5'd14: begin
				s.sel   = REG_CR3;
				s.value = MODE_SUB;
			end
			5'd3:  s.value = {SUB_HALF, scale};
			5'd6:  s.value = {SUB_4, scale};
			5'd9:  s.value = {SUB_8, scale};
			5'd12: s.value = {SUB_16, scale};
			5'd15: s.value = {SUB_32, scale};
			5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd18, 5'd20: begin
				s.kind = KIND_BURST;
				s.cnt  = CNT_ONE;
			end
			5'd17: begin
				s.sel   = REG_CR3;
				s.value = MODE_64;
			end
			5'd19: begin
				s.sel   = REG_CR3;
				s.value = MODE_128;
			end
			SLOT_DONE: s.kind = KIND_DONE;
			default: s.kind = KIND_DONE;
		endcase
		return s;
	endfunction

endpackage

// File: rtl/stepper_move_planner_core.sv
// Stepper move planner: turns a target position into driver register writes and step bursts.
//
// Input channel (in_valid / in_stall, payload target_position): one absolute target in
// 1/128 microstep units per item. Output channel (out_valid / out_stall): one command
// item per cycle unless stalled: register writes, step bursts, and a final "move finished"
// item with last set. Configuration (cfg_valid / cfg_ready / cfg_data) sets the coil current
// code; cfg_ready is always high and writes are expected only while the block is idle.
//
// An accepted item passes from the input register to the sequencer, which loads its first
// result into the output register.
// The output channel moves one result per cycle while not stalled; an item emits 1 + 2
// (full steps present) + 3 per set bit of 1/2..1/32 + 2 per set bit of 1/64 and 1/128
// results, 1 to 22 in all. The next item waits in the input register and enters the
// sequencer in the same cycle its predecessor's finished item is issued.
// Reset clears the position to zero, the current code to 10 and all valid flags.
// A stall on the output holds the result register and the sequencer; the input side then
// stalls once the input register is full.
module stepper_move_planner_core #(
	parameter int POSITION_BITS = smp_pkg::POSITION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input items
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [POSITION_BITS-1:0]     target_position,
	// result items
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          kind,
	output logic [1:0]                          reg_select,
	output logic [7:0]                          reg_value,
	output logic [smp_pkg::COUNT_W-1:0]         step_count,
	output logic                                step_direction,
	output logic [smp_pkg::MSP_W-1:0]           microstep_position,
	output logic                                last,
	// configuration
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [smp_pkg::SCALE_W-1:0]         cfg_data
);

	localparam int FULL_W = POSITION_BITS - smp_pkg::FRAC_BITS;
	localparam int FW     = (FULL_W > smp_pkg::COUNT_W) ? FULL_W : smp_pkg::COUNT_W;

	// Registers
	logic [smp_pkg::SCALE_W-1:0]      scale_q;
	logic [POSITION_BITS-1:0]         cur_pos_q;
	logic                             valid_s1;
	logic [POSITION_BITS:0]           diff_s1;
	logic [smp_pkg::MSP_W-1:0]        msp_s1;
	logic [smp_pkg::SLOT_COUNT-1:0]   mask_q;
	logic [smp_pkg::COUNT_W-1:0]      full_q;
	logic                             dir_q;
	logic [smp_pkg::MSP_W-1:0]        msp_q;
	logic                             out_valid_q;
	logic [1:0]                       kind_q;
	logic [1:0]                       sel_q;
	logic [7:0]                       value_q;
	logic [smp_pkg::COUNT_W-1:0]      count_q;
	logic                             dir_out_q;
	logic [smp_pkg::MSP_W-1:0]        msp_out_q;
	logic                             last_q;

	// Combinational
	logic                             in_accept;
	logic                             busy;
	logic                             out_load;
	logic                             xfer;
	logic [smp_pkg::SLOT_W-1:0]       slot;
	smp_pkg::slot_info_t              info;
	logic [POSITION_BITS:0]           mag_full;
	logic [POSITION_BITS-1:0]         mag;
	logic [FW-1:0]                    full_ext;
	logic [smp_pkg::COUNT_W-1:0]      full_sat;
	logic                             full_nz;
	logic                             dir_new;
	logic [smp_pkg::SLOT_COUNT-1:0]   mask_new;

	// Handshakes
	assign cfg_ready = 1'b1;
	assign busy      = |mask_q;
	assign out_load  = busy && (!out_valid_q || !out_stall);
	assign xfer      = valid_s1 && (!busy || (out_load && slot == smp_pkg::SLOT_DONE));
	assign in_stall  = valid_s1 && !xfer;
	assign in_accept = in_valid && !in_stall;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= smp_pkg::SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			scale_q <= cfg_data;
		end
	end

	// Input stage: signed distance from the current position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_pos_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (in_accept) begin
				cur_pos_q <= target_position;
				valid_s1  <= 1'b1;
			end else if (xfer) begin
				valid_s1  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			diff_s1 <= {target_position[POSITION_BITS-1], target_position}
			         - {cur_pos_q[POSITION_BITS-1], cur_pos_q};
			msp_s1  <= target_position[smp_pkg::MSP_W-1:0];
		end
	end

	// Magnitude, full-step count and the set of slots this move needs
	always_comb begin
		mag_full = diff_s1[POSITION_BITS] ? (~diff_s1 + 1'b1) : diff_s1;
		mag      = mag_full[POSITION_BITS-1:0];
		dir_new  = !diff_s1[POSITION_BITS] && (|diff_s1);
		full_ext = FW'(mag[POSITION_BITS-1:smp_pkg::FRAC_BITS]);
		full_nz  = |mag[POSITION_BITS-1:smp_pkg::FRAC_BITS];
		full_sat = (full_ext > FW'(smp_pkg::COUNT_MAX)) ? smp_pkg::COUNT_MAX
		         : full_ext[smp_pkg::COUNT_W-1:0];
		mask_new = '0;
		mask_new[0] = full_nz;
		mask_new[1] = full_nz;
		for (int i = 0; i < 5; i++) begin
			mask_new[2 + 3*i +: 3] = {3{mag[6 - i]}};
		end
		mask_new[17 +: 2] = {2{mag[1]}};
		mask_new[19 +: 2] = {2{mag[0]}};
		mask_new[smp_pkg::SLOT_DONE] = 1'b1;
	end

	// Next slot to issue: lowest pending one
	always_comb begin
		slot = '0;
		for (int i = smp_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				slot = smp_pkg::SLOT_W'(i);
			end
		end
		info = smp_pkg::slot_info(slot, scale_q);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (xfer) begin
			mask_q <= mask_new;
		end else if (out_load) begin
			mask_q <= mask_q & (mask_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			full_q <= full_sat;
			dir_q  <= dir_new;
			msp_q  <= msp_s1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q    <= info.kind;
			sel_q     <= info.sel;
			value_q   <= info.value;
			dir_out_q <= (info.kind == smp_pkg::KIND_BURST) ? dir_q : 1'b0;
			msp_out_q <= (info.kind == smp_pkg::KIND_DONE) ? msp_q : '0;
			last_q    <= (info.kind == smp_pkg::KIND_DONE);
			case (info.cnt)
				smp_pkg::CNT_FULL: count_q <= full_q;
				smp_pkg::CNT_ONE:  count_q <= smp_pkg::COUNT_W'(1);
				default:           count_q <= '0;
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign kind               = kind_q;
	assign reg_select         = sel_q;
	assign reg_value          = value_q;
	assign step_count         = count_q;
	assign step_direction     = dir_out_q;
	assign microstep_position = msp_out_q;
	assign last               = last_q;

endmodule

// File: rtl/smp_chk.sv
// Port-level checker for the stepper move planner, bound to the top level.
module smp_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [1:0]                   kind,
	input logic [1:0]                   reg_select,
	input logic [7:0]                   reg_value,
	input logic [smp_pkg::COUNT_W-1:0]  step_count,
	input logic                         step_direction,
	input logic [smp_pkg::MSP_W-1:0]    microstep_position,
	input logic                         last
);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(step_count)
			&& $stable(reg_value) && $stable(last))
		else $error("stalled result changed");

	// last marks exactly the finished item
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (kind == smp_pkg::KIND_DONE)))
		else $error("last does not match finished item");

	// Only bursts carry a count and direction, and a burst is never empty
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((kind == smp_pkg::KIND_BURST) ? (step_count != '0)
			: (step_count == '0 && !step_direction)))
		else $error("bad burst fields");

	// Position only on the finished item, register fields only on writes
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != smp_pkg::KIND_DONE |-> microstep_position == '0)
		else $error("position on non-finished item");

	a_regs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != smp_pkg::KIND_WRITE |-> reg_select == '0 && reg_value == '0)
		else $error("register fields on non-write item");

endmodule

bind stepper_move_planner_core smp_chk u_smp_chk (
	.clk                (clk),
	.arst_n             (arst_n),
	.out_valid          (out_valid),
	.out_stall          (out_stall),
	.kind               (kind),
	.reg_select         (reg_select),
	.reg_value          (reg_value),
	.step_count         (step_count),
	.step_direction     (step_direction),
	.microstep_position (microstep_position),
	.last               (last)
);
